// File: hw/rtl/gtu_pkg.sv
// ----------------------------------------------------------------------------
// gtu_pkg
// Shared constants and controller/datapath interface types for the GBK to
// Unicode stream decoder.
// ----------------------------------------------------------------------------
package gtu_pkg;

    localparam logic [7:0]  LEAD_LO     = 8'h81;
    localparam logic [7:0]  LEAD_HI     = 8'hFE;
    localparam logic [7:0]  TRAIL_LO    = 8'h40;
    localparam logic [7:0]  TRAIL_HI    = 8'hFE;
    localparam logic [15:0] ASCII_MAX   = 16'h007F;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;

    // s_tuser codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic setup;     // load code and search bounds
        logic sel;       // 0: first code of the beat, 1: second code
        logic search;    // one compare step against the RAM read data
        logic push;      // move the result into the output register
        logic run_last;  // pushed result is the last one of its beat
    } gtu_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] n_results;   // results caused by the beat on s_tdata
        logic       search_done; // lookup resolved this cycle
        logic       out_free;    // output register can take a result
    } gtu_sts_t;

endpackage

// File: hw/rtl/gbk_to_unicode_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// gbk_to_unicode_stream_decoder_core
// GBK byte stream to 16-bit Unicode decoder with a host-loaded sorted table.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries load beats (s_tuser = 0) that write one table slot
//   {key, value}, and decode beats (s_tuser = 1) that carry one GBK byte;
//   s_tlast ends the string and flushes a pending lead byte.
//   m_ channel returns zero, one or two code points per decode beat; m_tlast
//   marks the last result of a beat, m_tuser[1] the end of the string.
//   cfg_wr_en / cfg_wr_data set the number of sorted entries searched; write
//   only while the block is idle.
// Sequencing:
//   A load beat or a beat that only stores a lead byte needs no lookup. A
//   decode beat is accepted, then each result runs setup, the search and one
//   push into the output register. A code up to 0x7F or an empty range
//   resolves on the first search step; else the search does one RAM read and
//   compare per cycle, with the entry count clamped to the table depth.
// Reset clears the pending lead byte, the entry count and the output valid;
// the table contents are kept and are undefined until written.
// A stalled receiver holds the result in the output register; the next beat
// is still accepted and its lookup runs until its result needs the register.
// ----------------------------------------------------------------------------
module gbk_to_unicode_stream_decoder_core
    import gtu_pkg::*;
#(
    parameter int TABLE_DEPTH = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: number of sorted entries searched
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input: tdata = {pad, entry_value[54:39], entry_key[38:23],
    //                 entry_index[22:8], data_byte[7:0]}; tuser[0] = cmd
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // data_byte, entry_index, entry_key, entry_value
    input  logic [0:0]  s_tuser,   // cmd
    input  logic        s_tlast,   // last_byte
    // output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_point
    output logic [1:0]  m_tuser,   // mapped, string_end
    output logic        m_tlast    // run_last
);

    gtu_cmd_t cmd;
    gtu_sts_t sts;

    gtu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gtu_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: hw/rtl/gtu_ram.sv
// ----------------------------------------------------------------------------
// gtu_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module gtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/gtu_ctrl.sv
// ----------------------------------------------------------------------------
// gtu_ctrl
// Controller: sequences up to two table lookups per input beat and hands
// each result to the output register.
// ----------------------------------------------------------------------------
module gtu_ctrl
    import gtu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  gtu_sts_t sts,
    output gtu_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEARCH,
        ST_PUSH
    } state_t;

    state_t state_reg;
    logic   sel_reg;
    logic   two_reg;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        cmd.accept   = accept;
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.sel      = sel_reg;
        cmd.search   = (state_reg == ST_SEARCH);
        cmd.push     = (state_reg == ST_PUSH) && sts.out_free;
        cmd.run_last = !(two_reg && !sel_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            two_reg   <= 1'b0;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && sts.n_results != 2'd0) begin
                        sel_reg   <= 1'b0;
                        two_reg   <= (sts.n_results == 2'd2);
                        ready_reg <= 1'b0;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (sts.search_done) begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    // hold the result until the output register frees up
                    if (sts.out_free) begin
                        if (two_reg && !sel_reg) begin
                            sel_reg   <= 1'b1;
                            state_reg <= ST_SETUP;
                        end else begin
                            ready_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/gtu_dp.sv
// ----------------------------------------------------------------------------
// gtu_dp
// Datapath: byte pairing, lookup table RAM, binary search bounds and the
// output register.
// ----------------------------------------------------------------------------
module gtu_dp
    import gtu_pkg::*;
#(
    parameter int TABLE_DEPTH = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [55:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  gtu_cmd_t    cmd,
    output gtu_sts_t    sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // input fields
    logic [7:0]  in_byte;
    logic [14:0] in_index;
    logic [15:0] in_key;
    logic [15:0] in_value;

    assign in_byte  = s_tdata[7:0];
    assign in_index = s_tdata[22:8];
    assign in_key   = s_tdata[38:23];
    assign in_value = s_tdata[54:39];

    // pairing state and job registers
    logic        lead_pending_reg;
    logic [7:0]  lead_value_reg;
    logic [15:0] key_count_reg;
    logic [15:0] code0_reg;
    logic [7:0]  code1_reg;
    logic        last_reg;

    logic        is_lead;
    logic        is_trail;
    logic [1:0]  dec_n;
    logic [15:0] dec_code0;
    logic        dec_pending;

    // search registers
    logic [15:0]   cur_code_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [AW-1:0] mid_reg;
    logic [CW-1:0] lo_next;
    logic [CW-1:0] hi_next;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_next;
    logic [CW-1:0] n_eff;
    logic [15:0]   res_cp_reg;
    logic          res_hit_reg;

    // RAM
    logic          wr_en;
    logic [31:0]   rd_data;
    logic [15:0]   rd_key;
    logic [15:0]   rd_value;
    logic          pass;
    logic          empty;
    logic          key_eq;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        m_mapped_reg;
    logic        m_end_reg;
    logic        m_last_reg;

    // ---------------------------------------------------------------- pairing
    assign is_lead  = (in_byte >= LEAD_LO) && (in_byte <= LEAD_HI);
    assign is_trail = (in_byte >= TRAIL_LO) && (in_byte <= TRAIL_HI);

    always_comb begin
        dec_n       = 2'd0;
        dec_code0   = {8'h00, in_byte};
        dec_pending = 1'b0;
        if (lead_pending_reg) begin
            if (is_trail) begin
                dec_n     = 2'd1;
                dec_code0 = {lead_value_reg, in_byte};
            end else begin
                dec_code0 = {8'h00, lead_value_reg};
                if (is_lead && !s_tlast) begin
                    dec_n       = 2'd1;
                    dec_pending = 1'b1;
                end else begin
                    dec_n = 2'd2;
                end
            end
        end else begin
            if (is_lead && !s_tlast) begin
                dec_pending = 1'b1;
            end else begin
                dec_n = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg <= 1'b0;
            lead_value_reg   <= 8'h00;
            key_count_reg    <= 16'h0000;
        end else begin
            if (cfg_wr_en) begin
                key_count_reg <= cfg_wr_data;
            end
            if (cmd.accept && s_tuser[0] == CMD_DECODE) begin
                lead_pending_reg <= dec_pending;
                if (dec_pending) begin
                    lead_value_reg <= in_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_tuser[0] == CMD_DECODE) begin
            code0_reg <= dec_code0;
            code1_reg <= in_byte;
            last_reg  <= s_tlast;
        end
    end

    // ---------------------------------------------------------------- table
    assign wr_en = cmd.accept && (s_tuser[0] == CMD_LOAD)
                   && (32'(in_index) < TABLE_DEPTH);

    gtu_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data ({in_key, in_value}),
        .rd_addr (mid_next),
        .rd_data (rd_data)
    );

    assign rd_key   = rd_data[31:16];
    assign rd_value = rd_data[15:0];

    // ---------------------------------------------------------------- search
    assign n_eff = (32'(key_count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                      : CW'(key_count_reg);

    assign pass   = (cur_code_reg <= ASCII_MAX);
    assign empty  = !(lo_reg < hi_reg);
    assign key_eq = (rd_key == cur_code_reg);

    assign sts.search_done = pass || empty || key_eq;
    assign sts.n_results   = (s_tuser[0] == CMD_DECODE) ? dec_n : 2'd0;
    assign sts.out_free    = !m_valid_reg || m_tready;

    // hi is one past the last live slot; mid = floor((lo + hi - 1) / 2)
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.setup) begin
            lo_next = '0;
            hi_next = n_eff;
        end else if (cmd.search && !sts.search_done) begin
            if (rd_key < cur_code_reg) begin
                lo_next = CW'(mid_reg) + CW'(1);
            end else begin
                hi_next = CW'(mid_reg);
            end
        end
        mid_sum  = {1'b0, lo_next} + {1'b0, hi_next} - (CW + 1)'(1);
        mid_next = mid_sum[AW:1];
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (cmd.setup) begin
            cur_code_reg <= cmd.sel ? {8'h00, code1_reg} : code0_reg;
        end
        if (cmd.search && sts.search_done) begin
            if (pass) begin
                res_cp_reg  <= cur_code_reg;
                res_hit_reg <= 1'b1;
            end else if (!empty && key_eq) begin
                res_cp_reg  <= rd_value;
                res_hit_reg <= 1'b1;
            end else begin
                res_cp_reg  <= REPLACEMENT;
                res_hit_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg   <= res_cp_reg;
            m_mapped_reg <= res_hit_reg;
            m_last_reg   <= cmd.run_last;
            m_end_reg    <= cmd.run_last && last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_end_reg, m_mapped_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: hw/rtl/gtu_checker.sv
// ----------------------------------------------------------------------------
// gtu_checker
// Port-level checks for the GBK to Unicode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module gtu_checker
    import gtu_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // end of string only on the last result of a beat
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("string end without run last");

    // an unmapped code is always the replacement character
    a_unmapped_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == REPLACEMENT)
        else $error("unmapped result is not the replacement code");

endmodule

bind gbk_to_unicode_stream_decoder_core gtu_checker u_gtu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
